### hdl/lpct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpct_pkg;

    // request kinds carried on the command field
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOGIN  = 1'b1;

    // result codes on the status field
    typedef enum logic [2:0] {
        RES_INSERTED  = 3'd0,
        RES_DUPLICATE = 3'd1,
        RES_FULL      = 3'd2,
        RES_GRANTED   = 3'd3,
        RES_WRONG     = 3'd4,
        RES_UNKNOWN   = 3'd5
    } result_code_t;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DELIVER
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic hash_step;
        logic probe_step;
        logic clear_step;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hash_last;
        logic probe_done;
        logic clear_last;
    } dp_stat_t;

endpackage

`default_nettype wire

### hdl/lpct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lpct_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire              out_stall,
    output lpct_pkg::dp_cmd_t cmd,
    input  lpct_pkg::dp_stat_t stat
);
    import lpct_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and output flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                cmd.probe_step = 1'b1;
                if (stat.probe_done)
                begin
                    state_next = S_DELIVER;
                end
            end
            S_DELIVER:
            begin
                // hand over once the output register is free or being taken
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### hdl/lpct_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lpct_datapath #(
    parameter int SLOTS     = 23,
    parameter int KEY_BYTES = 8
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               command,
    input  wire  [63:0]       user_key,
    input  wire  [63:0]       secret,
    input  lpct_pkg::dp_cmd_t cmd,
    output lpct_pkg::dp_stat_t stat,
    output logic [2:0]        status,
    output logic              granted,
    output logic [4:0]        slot
);
    import lpct_pkg::*;

    localparam int SW  = $clog2(SLOTS);
    localparam int BCW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    // quotient bits of (h*31 + byte) / SLOTS
    localparam int QB  = $clog2(31 + 256 / SLOTS + 1);
    localparam int RW  = $clog2(31 * SLOTS + 256) + QB + 1;

    // request registers
    logic         cmd_reg;
    logic [63:0]  key_reg;
    logic [63:0]  secret_reg;
    logic [SW-1:0]  hash_reg;
    logic [BCW-1:0] bcnt_reg;
    logic [SW-1:0]  cur_reg;
    logic [SW-1:0]  n_reg;
    result_code_t   res_code_reg;
    logic [SW-1:0]  res_slot_reg;
    logic [2:0]     status_reg;
    logic           granted_reg;
    logic [4:0]     slot_reg;

    // table storage
    logic         occ_mem [SLOTS];
    logic [63:0]  key_mem [SLOTS];
    logic [63:0]  sec_mem [SLOTS];
    logic         occ_rd_reg;
    logic [63:0]  key_rd_reg;
    logic [63:0]  sec_rd_reg;

    logic [63:0]    key_trim;
    logic [63:0]    secret_trim;
    logic [7:0]     cur_byte;
    logic [SW-1:0]  h_red;
    logic [SW-1:0]  h_new;
    logic [SW-1:0]  cur_inc;
    logic [SW-1:0]  rd_addr;
    logic           probe_last;
    logic           probe_done;
    logic           ins_we;
    logic           occ_we;
    result_code_t   res_code;
    logic [SW-1:0]  res_slot;

    // clear bytes from the first zero byte on, and key bytes beyond KEY_BYTES
    always_comb
    begin
        logic keep_k;
        logic keep_s;
        keep_k = 1'b1;
        keep_s = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (user_key[8*i +: 8] == 8'd0 || i >= KEY_BYTES)
            begin
                keep_k = 1'b0;
            end
            if (secret[8*i +: 8] == 8'd0)
            begin
                keep_s = 1'b0;
            end
            key_trim[8*i +: 8]    = keep_k ? user_key[8*i +: 8] : 8'd0;
            secret_trim[8*i +: 8] = keep_s ? secret[8*i +: 8] : 8'd0;
        end
    end

    // one hash byte per cycle, residue kept below SLOTS
    assign cur_byte       = key_reg[{bcnt_reg, 3'b000} +: 8];
    assign stat.hash_last = (cur_byte == 8'd0) || (bcnt_reg == BCW'(KEY_BYTES - 1));

    always_comb
    begin
        logic [RW-1:0] rx;
        rx = (RW'(hash_reg) << 5) - RW'(hash_reg) + RW'(cur_byte);
        for (int k = QB - 1; k >= 0; k--)
        begin
            if (rx >= (RW'(SLOTS) << k))
            begin
                rx = rx - (RW'(SLOTS) << k);
            end
        end
        h_red = SW'(rx);
    end

    assign h_new   = (cur_byte != 8'd0) ? h_red : hash_reg;
    assign cur_inc = (cur_reg == SW'(SLOTS - 1)) ? '0 : SW'(cur_reg + 1'b1);
    assign rd_addr = cmd.probe_step ? cur_inc : h_new;

    // probe decision on the slot whose data is in the read registers
    assign probe_last = (n_reg == SW'(SLOTS - 1));

    always_comb
    begin
        probe_done = 1'b0;
        ins_we     = 1'b0;
        res_code   = (cmd_reg == CMD_INSERT) ? RES_FULL : RES_UNKNOWN;
        if (cmd_reg == CMD_INSERT)
        begin
            if (!occ_rd_reg)
            begin
                probe_done = 1'b1;
                ins_we     = cmd.probe_step;
                res_code   = RES_INSERTED;
            end
            else if (key_rd_reg == key_reg)
            begin
                probe_done = 1'b1;
                res_code   = RES_DUPLICATE;
            end
            else if (probe_last)
            begin
                probe_done = 1'b1;
            end
        end
        else
        begin
            if (!occ_rd_reg)
            begin
                probe_done = 1'b1;
            end
            else if (key_rd_reg == key_reg)
            begin
                probe_done = 1'b1;
                res_code   = (sec_rd_reg == secret_reg) ? RES_GRANTED : RES_WRONG;
            end
            else if (probe_last)
            begin
                probe_done = 1'b1;
            end
        end
        res_slot = (res_code == RES_FULL || res_code == RES_UNKNOWN) ? '0 : cur_reg;
    end

    assign stat.probe_done = probe_done;
    assign stat.clear_last = (cur_reg == SW'(SLOTS - 1));
    assign occ_we          = cmd.clear_step || ins_we;

    // table memories, registered read
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[cur_reg] <= !cmd.clear_step;
        end
        if (ins_we)
        begin
            key_mem[cur_reg] <= key_reg;
            sec_mem[cur_reg] <= secret_reg;
        end
        occ_rd_reg <= occ_mem[rd_addr];
        key_rd_reg <= key_mem[rd_addr];
        sec_rd_reg <= sec_mem[rd_addr];
    end

    // walk control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            bcnt_reg <= '0;
            cur_reg  <= '0;
            n_reg    <= '0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                hash_reg <= '0;
                bcnt_reg <= '0;
            end
            if (cmd.hash_step)
            begin
                hash_reg <= h_new;
                bcnt_reg <= BCW'(bcnt_reg + 1'b1);
                if (stat.hash_last)
                begin
                    cur_reg <= h_new;
                    n_reg   <= '0;
                end
            end
            if (cmd.probe_step && !probe_done)
            begin
                cur_reg <= cur_inc;
                n_reg   <= SW'(n_reg + 1'b1);
            end
            if (cmd.clear_step)
            begin
                cur_reg <= cur_inc;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            cmd_reg    <= command;
            key_reg    <= key_trim;
            secret_reg <= secret_trim;
        end
        if (cmd.probe_step && probe_done)
        begin
            res_code_reg <= res_code;
            res_slot_reg <= res_slot;
        end
        if (cmd.load_out)
        begin
            status_reg  <= res_code_reg;
            granted_reg <= (res_code_reg == RES_GRANTED);
            slot_reg    <= 5'(res_slot_reg);
        end
    end

    assign status  = status_reg;
    assign granted = granted_reg;
    assign slot    = slot_reg;

endmodule

`default_nettype wire

### hdl/linear_probe_credential_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// request   in         in_valid / in_stall  command, user_key, secret
// result    out        out_valid / out_stall status, granted, slot
//
// a request runs from accept through hash steps, one per key byte up to and
// including the first zero byte (at most KEY_BYTES), probe steps, one per table
// slot visited (1 to SLOTS) as the slot memory has a single read port, and a
// hand-over step; no new request is taken before the hand-over
// after reset a clearing pass over all SLOTS slots wipes the slot marks; no request
// is taken meanwhile
// the result waits in an output register; a stalled result holds the block in
// its hand-over step once the next result is ready

module linear_probe_credential_table_core #(
    parameter int SLOTS     = 23,
    parameter int KEY_BYTES = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         command,
    input  wire  [63:0] user_key,
    input  wire  [63:0] secret,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [2:0]  status,
    output logic        granted,
    output logic [4:0]  slot
);
    import lpct_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    lpct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // hash, table and result registers
    lpct_datapath #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .command  (command),
        .user_key (user_key),
        .secret   (secret),
        .cmd      (cmd),
        .stat     (stat),
        .status   (status),
        .granted  (granted),
        .slot     (slot)
    );

    // granted flag agrees with the result code
    a_granted_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (granted == (status == RES_GRANTED)))
        else $error("granted flag disagrees with status");

    // a miss or a full table reports slot zero
    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == RES_FULL || status == RES_UNKNOWN)) |-> (slot == 5'd0))
        else $error("nonzero slot on miss or full");

    // block is busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while previous one in flight");

    // the walk stops once a decision is made
    a_walk_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.probe_step && stat.probe_done) |=> !cmd.probe_step)
        else $error("probing continued after decision");

endmodule

`default_nettype wire
